### sv/pne_pkg.sv
`default_nettype none

package pne_pkg;

  // Window geometry.
  localparam int MAX_RADIUS = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int WIN = 2 * MAX_RADIUS + 1;
  localparam int NCOEF = WIN * WIN;
  localparam int IDXW = $clog2(WIN);
  localparam int FILLW = $clog2(WIN + 1);
  localparam int OFW = $clog2(MAX_RADIUS + 1) + 1;
  localparam int ADRW = 9;
  localparam int RADW = 4;
  localparam int LANEW = 16;
  localparam int WORDW = 4 * LANEW;
  localparam int CFGW = 16;

  // Datapath widths.
  localparam int OPW = 24;
  localparam int PRW = 2 * OPW + 3;
  localparam int ACCW = 56;
  localparam int QW = 40;
  localparam int QLOW = 18;
  localparam int FRAC = 14;
  localparam int WFRAC = 12;

  // Sequencer last-step and half-way step indexes.
  localparam int STEPW = 5;
  localparam logic [STEPW-1:0] SPM_LAST = STEPW'(5);
  localparam logic [STEPW-1:0] XPM_HALF = STEPW'(9);
  localparam logic [STEPW-1:0] XPM_LAST = STEPW'(18);
  localparam logic [STEPW-1:0] FIN_LAST = STEPW'(3);

  // Request codes.
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_SPM_COEF = 2'd1;
  localparam logic [1:0] REQ_XPM_COEF = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SPM_RADIUS = 2'd0;
  localparam logic [1:0] CFG_XPM_RADIUS = 2'd1;
  localparam logic [1:0] CFG_INV_W_RE = 2'd2;
  localparam logic [1:0] CFG_INV_W_IM = 2'd3;

  localparam logic signed [PRW-1:0] RND_HALF = PRW'(1 << (FRAC - 1));
  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(32767);
  localparam logic signed [ACCW-1:0] SAT_LO = ACCW'(-32768);

  typedef logic signed [OPW-1:0] op_t;

  typedef struct packed {
    logic signed [OPW-1:0] re;
    logic signed [OPW-1:0] im;
  } cop_t;

  typedef struct packed {
    logic signed [PRW-1:0] re;
    logic signed [PRW-1:0] im;
  } cprod_t;

  typedef struct packed {
    logic conj_a;
    logic conj_b;
  } mul_ctrl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPM,
    ST_XPM,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    ASRC_SMP,
    ASRC_CSPM,
    ASRC_CXPM,
    ASRC_WGT
  } asrc_e;

  typedef enum logic [2:0] {
    BSRC_T0,
    BSRC_T1,
    BSRC_T2,
    BSRC_QH,
    BSRC_QL,
    BSRC_ONE
  } bsrc_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_T0,
    OP_T1_SET,
    OP_T1_ADD,
    OP_T2_SET2,
    OP_T2_ADD2,
    OP_T2_ADD,
    OP_ACC_ADD,
    OP_ACC_SET,
    OP_ACC_SHADD,
    OP_Q,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    W_L,
    W_C,
    W_R
  } wsel_e;

  typedef enum logic [1:0] {
    OFS_M,
    OFS_N,
    OFS_MN
  } osel_e;

  // Round a product at scale 2^28 back to scale 2^14.
  function automatic op_t rnd_op(input logic signed [PRW-1:0] p);
    logic signed [PRW-1:0] t;
    t = p + RND_HALF;
    return op_t'(t >>> FRAC);
  endfunction

  // Saturate to a signed 16-bit lane.
  function automatic logic signed [LANEW-1:0] sat16(input logic signed [ACCW-1:0] v);
    logic signed [LANEW-1:0] r;
    if (v > SAT_HI) begin
      r = LANEW'(32767);
    end else if (v < SAT_LO) begin
      r = LANEW'(-32768);
    end else begin
      r = v[LANEW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/pne_cmul.sv
`default_nettype none

// Shared complex multiplier: exact product of a and b, each optionally conjugated.
module pne_cmul (
  input  pne_pkg::cop_t      a_i,
  input  pne_pkg::cop_t      b_i,
  input  pne_pkg::mul_ctrl_t ctrl_i,
  output pne_pkg::cprod_t    p_o
);

  localparam int EW = pne_pkg::OPW + 1;

  logic signed [EW-1:0]   ar, ai, br, bi;
  logic signed [2*EW-1:0] rr, ii, ri, ir;

  // Widen before negation so that the most negative value conjugates cleanly.
  always_comb begin
    ar = EW'(a_i.re);
    br = EW'(b_i.re);
    ai = ctrl_i.conj_a ? -EW'(a_i.im) : EW'(a_i.im);
    bi = ctrl_i.conj_b ? -EW'(b_i.im) : EW'(b_i.im);
  end

  assign rr = ar * br;
  assign ii = ai * bi;
  assign ri = ar * bi;
  assign ir = ai * br;

  assign p_o.re = pne_pkg::PRW'(rr) - pne_pkg::PRW'(ii);
  assign p_o.im = pne_pkg::PRW'(ri) + pne_pkg::PRW'(ir);

endmodule

`default_nettype wire

### sv/perturbation_nonlinear_equalizer_top.sv
// Coefficient writes and window-filling samples only update state; a sample that
// completes the window starts a computation over both polarizations that walks
// the self-phase and cross-phase diamonds, 2R*R+2R+1 terms for radius R; the one shared
// complex multiplier does one product per cycle. No overlap between items.
// After reset a clearing pass zeroes all 289 entries of both coefficient tables while
// the input is stalled; configuration writes are taken throughout.
`default_nettype none

module perturbation_nonlinear_equalizer_top #(
  parameter int SAMPLE_BITS = pne_pkg::SAMPLE_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [1:0]                          cfg_idx_i,
  input  wire logic [pne_pkg::CFGW-1:0]            cfg_data_i,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic [1:0]                          req_type_i,
  input  wire logic [pne_pkg::ADRW-1:0]            coef_index_i,
  input  wire logic signed [pne_pkg::LANEW-1:0]    coef_re_i,
  input  wire logic signed [pne_pkg::LANEW-1:0]    coef_im_i,
  input  wire logic [pne_pkg::WORDW-1:0]           tx_left_i,
  input  wire logic [pne_pkg::WORDW-1:0]           tx_center_i,
  input  wire logic [pne_pkg::WORDW-1:0]           tx_right_i,
  input  wire logic [pne_pkg::WORDW-1:0]           rx_center_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic signed [pne_pkg::LANEW-1:0]    eq_x_re_o,
  output      logic signed [pne_pkg::LANEW-1:0]    eq_x_im_o,
  output      logic signed [pne_pkg::LANEW-1:0]    eq_y_re_o,
  output      logic signed [pne_pkg::LANEW-1:0]    eq_y_im_o
);

  localparam int WIN = pne_pkg::WIN;
  localparam int MAXR = pne_pkg::MAX_RADIUS;
  localparam int OFW = pne_pkg::OFW;
  localparam int IDXW = pne_pkg::IDXW;
  localparam int ADRW = pne_pkg::ADRW;
  localparam int ACCW = pne_pkg::ACCW;
  localparam int QW = pne_pkg::QW;
  localparam int OPW = pne_pkg::OPW;
  localparam int LANEW = pne_pkg::LANEW;
  localparam int WORDW = pne_pkg::WORDW;
  localparam int STEPW = pne_pkg::STEPW;
  localparam int FILLW = pne_pkg::FILLW;
  localparam int RADW = pne_pkg::RADW;
  localparam int FRAC = pne_pkg::FRAC;
  localparam int WFRAC = pne_pkg::WFRAC;
  localparam int QLOW = pne_pkg::QLOW;

  localparam logic [LANEW-1:0] KEEP =
      ~((LANEW'(1) << (LANEW - SAMPLE_BITS)) - LANEW'(1));
  localparam logic [WORDW-1:0] KEEP64 = {4{KEEP}};
  localparam logic signed [OFW:0] MAX_S = (OFW + 1)'(MAXR);
  localparam logic [RADW-1:0] MAX_RAD = RADW'(MAXR);
  localparam logic signed [ACCW-1:0] Q_HALF = ACCW'(1 << (FRAC - 1));
  localparam logic signed [ACCW-1:0] W_HALF = ACCW'(1 << (WFRAC - 1));

  // Configuration registers.
  logic [RADW-1:0]         spm_radius_q, xpm_radius_q;
  logic signed [LANEW-1:0] inv_w_re_q, inv_w_im_q;

  // Windows and coefficient tables.
  logic [WORDW-1:0] lwin_q [WIN];
  logic [WORDW-1:0] cwin_q [WIN];
  logic [WORDW-1:0] rwin_q [WIN];
  logic [WORDW-1:0] rxd_q [MAXR+1];
  logic [2*LANEW-1:0] spm_mem [pne_pkg::NCOEF];
  logic [2*LANEW-1:0] xpm_mem [pne_pkg::NCOEF];
  logic [2*LANEW-1:0] cs_q, cx_q;

  // Sequencer.
  pne_pkg::state_e         state_q, state_d;
  logic [STEPW-1:0]        step_q, step_d;
  logic                    pol_q, pol_d;
  logic signed [OFW:0]     m_q, m_d, n_q, n_d;
  logic [ADRW-1:0]         clr_q, clr_d;
  logic [FILLW-1:0]        fill_q;

  // Datapath state.
  pne_pkg::cop_t           t0_q, t1_q, t2_q;
  logic signed [ACCW-1:0]  acc_re_q, acc_im_q;
  logic signed [QW-1:0]    q_re_q, q_im_q;
  logic signed [LANEW-1:0] res_q [4];
  logic signed [LANEW-1:0] out_q [4];
  logic                    out_valid_q;

  // Control decode.
  pne_pkg::asrc_e          a_src;
  pne_pkg::bsrc_e          b_src;
  pne_pkg::op_e            op;
  pne_pkg::wsel_e          wsel;
  pne_pkg::osel_e          osel;
  logic                    lpol;
  pne_pkg::mul_ctrl_t      mctl;

  logic                    in_acc, smp_acc, start_s, fill_full, right_s, load_out;
  logic [RADW-1:0]         cr, dr;
  logic signed [OFW:0]     cr_s, dr_s, rad_s, mabs, nabs, b_cur, m_next, mabs_next, n_first;
  logic                    last_n, last_m;
  logic signed [OFW:0]     np, dsel, d_idx;
  logic [IDXW-1:0]         smp_idx, mi, ni;
  logic [ADRW-1:0]         ra, wa;
  logic [2*LANEW-1:0]      wd;
  logic                    we_s, we_x, clearing;
  logic [WORDW-1:0]        smp_word;
  pne_pkg::cop_t           a_op, b_op;
  pne_pkg::cprod_t         prod;
  pne_pkg::op_t            rp_re, rp_im;
  logic signed [LANEW-1:0] rx_re, rx_im;
  logic signed [ACCW-1:0]  qt_re, qt_im, ow_re, ow_im;

  // Handshake.
  assign in_stall_o = (state_q != pne_pkg::ST_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign smp_acc = in_acc && (req_type_i == pne_pkg::REQ_SAMPLE);
  assign fill_full = (fill_q == FILLW'(WIN)) || (fill_q == FILLW'(WIN - 1));
  assign start_s = smp_acc && fill_full;
  assign load_out = (state_q == pne_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spm_radius_q <= '0;
      xpm_radius_q <= '0;
      inv_w_re_q <= LANEW'(4096);
      inv_w_im_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pne_pkg::CFG_SPM_RADIUS: spm_radius_q <= cfg_data_i[RADW-1:0];
        pne_pkg::CFG_XPM_RADIUS: xpm_radius_q <= cfg_data_i[RADW-1:0];
        pne_pkg::CFG_INV_W_RE:   inv_w_re_q <= cfg_data_i;
        pne_pkg::CFG_INV_W_IM:   inv_w_im_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sample windows shift on each sample transfer; lanes keep their top bits only.
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      for (int i = 0; i < WIN - 1; i++) begin
        lwin_q[i] <= lwin_q[i+1];
        cwin_q[i] <= cwin_q[i+1];
        rwin_q[i] <= rwin_q[i+1];
      end
      for (int i = 0; i < MAXR; i++) begin
        rxd_q[i] <= rxd_q[i+1];
      end
      lwin_q[WIN-1] <= tx_left_i & KEEP64;
      cwin_q[WIN-1] <= tx_center_i & KEEP64;
      rwin_q[WIN-1] <= tx_right_i & KEEP64;
      rxd_q[MAXR] <= rx_center_i & KEEP64;
    end
  end

  // Fill count saturates at the window length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (smp_acc && (fill_q != FILLW'(WIN))) begin
      fill_q <= fill_q + FILLW'(1);
    end
  end

  // Coefficient tables: one write port shared by the clearing pass and coefficient
  // transfers, registered read at the current diamond position.
  assign clearing = (state_q == pne_pkg::ST_CLEAR);
  assign wa = clearing ? clr_q : coef_index_i;
  assign wd = clearing ? '0 : {coef_re_i, coef_im_i};
  assign we_s = clearing || (in_acc && (req_type_i == pne_pkg::REQ_SPM_COEF) &&
                             (coef_index_i < ADRW'(pne_pkg::NCOEF)));
  assign we_x = clearing || (in_acc && (req_type_i == pne_pkg::REQ_XPM_COEF) &&
                             (coef_index_i < ADRW'(pne_pkg::NCOEF)));
  assign mi = IDXW'(m_q + MAX_S);
  assign ni = IDXW'(n_q + MAX_S);
  assign ra = ADRW'(ADRW'(mi) * ADRW'(WIN) + ADRW'(ni));

  always_ff @(posedge clk_i) begin
    if (we_s) begin
      spm_mem[wa] <= wd;
    end
    if (we_x) begin
      xpm_mem[wa] <= wd;
    end
    cs_q <= spm_mem[ra];
    cx_q <= xpm_mem[ra];
  end

  // Diamond walk bookkeeping.
  assign cr = (spm_radius_q > MAX_RAD) ? MAX_RAD : spm_radius_q;
  assign dr = (xpm_radius_q > MAX_RAD) ? MAX_RAD : xpm_radius_q;
  assign cr_s = (OFW + 1)'(cr);
  assign dr_s = (OFW + 1)'(dr);
  assign rad_s = (state_q == pne_pkg::ST_XPM) ? dr_s : cr_s;
  assign mabs = (m_q < 0) ? -m_q : m_q;
  assign nabs = (n_q < 0) ? -n_q : n_q;
  assign b_cur = rad_s - mabs;
  assign last_n = (n_q == b_cur);
  assign last_m = (m_q == rad_s);
  assign m_next = m_q + (OFW + 1)'(1);
  assign mabs_next = (m_next < 0) ? -m_next : m_next;
  assign n_first = mabs_next - rad_s;

  // Next state and micro-step decode.
  always_comb begin
    state_d = state_q;
    step_d = step_q;
    pol_d = pol_q;
    m_d = m_q;
    n_d = n_q;
    clr_d = clr_q;
    right_s = 1'b0;
    a_src = pne_pkg::ASRC_SMP;
    b_src = pne_pkg::BSRC_ONE;
    op = pne_pkg::OP_NONE;
    wsel = pne_pkg::W_C;
    osel = pne_pkg::OFS_M;
    lpol = pol_q;
    mctl = '0;
    unique case (state_q)
      pne_pkg::ST_CLEAR: begin
        clr_d = clr_q + ADRW'(1);
        if (clr_q == ADRW'(pne_pkg::NCOEF - 1)) begin
          state_d = pne_pkg::ST_IDLE;
        end
      end
      pne_pkg::ST_IDLE: begin
        if (start_s) begin
          state_d = pne_pkg::ST_SPM;
          step_d = '0;
          pol_d = 1'b0;
          m_d = -cr_s;
          n_d = '0;
        end
      end
      pne_pkg::ST_SPM: begin
        // Self-phase term: pair product of both polarizations, then sample, then coefficient.
        unique case (step_q)
          STEPW'(0): begin osel = pne_pkg::OFS_MN; lpol = 1'b0; op = pne_pkg::OP_T0; end
          STEPW'(1): begin
            osel = pne_pkg::OFS_N; lpol = 1'b0; b_src = pne_pkg::BSRC_T0;
            mctl.conj_b = 1'b1; op = pne_pkg::OP_T1_SET;
          end
          STEPW'(2): begin osel = pne_pkg::OFS_MN; lpol = 1'b1; op = pne_pkg::OP_T0; end
          STEPW'(3): begin
            osel = pne_pkg::OFS_N; lpol = 1'b1; b_src = pne_pkg::BSRC_T0;
            mctl.conj_b = 1'b1; op = pne_pkg::OP_T1_ADD;
          end
          STEPW'(4): begin
            osel = pne_pkg::OFS_M; b_src = pne_pkg::BSRC_T1; op = pne_pkg::OP_T1_SET;
          end
          default: begin
            a_src = pne_pkg::ASRC_CSPM; b_src = pne_pkg::BSRC_T1; op = pne_pkg::OP_ACC_ADD;
          end
        endcase
        if (step_q == pne_pkg::SPM_LAST) begin
          step_d = '0;
          if (last_n && last_m) begin
            state_d = pne_pkg::ST_XPM;
            m_d = -dr_s;
            n_d = '0;
          end else if (last_n) begin
            m_d = m_next;
            n_d = n_first;
          end else begin
            n_d = n_q + (OFW + 1)'(1);
          end
        end else begin
          step_d = step_q + STEPW'(1);
        end
      end
      pne_pkg::ST_XPM: begin
        // Cross-phase term: three triple products per neighbor, then coefficient.
        right_s = (step_q >= pne_pkg::XPM_HALF);
        wsel = right_s ? pne_pkg::W_R : pne_pkg::W_L;
        unique case (right_s ? step_q - pne_pkg::XPM_HALF : step_q)
          STEPW'(0): begin wsel = pne_pkg::W_C; osel = pne_pkg::OFS_M; op = pne_pkg::OP_T0; end
          STEPW'(1): begin osel = pne_pkg::OFS_N; b_src = pne_pkg::BSRC_T0; op = pne_pkg::OP_T0; end
          STEPW'(2): begin
            osel = pne_pkg::OFS_MN; b_src = pne_pkg::BSRC_T0; mctl.conj_a = 1'b1;
            op = right_s ? pne_pkg::OP_T2_ADD2 : pne_pkg::OP_T2_SET2;
          end
          STEPW'(3): begin wsel = pne_pkg::W_C; osel = pne_pkg::OFS_M; op = pne_pkg::OP_T0; end
          STEPW'(4): begin
            osel = pne_pkg::OFS_N; lpol = !pol_q; b_src = pne_pkg::BSRC_T0; op = pne_pkg::OP_T0;
          end
          STEPW'(5): begin
            osel = pne_pkg::OFS_MN; lpol = !pol_q; b_src = pne_pkg::BSRC_T0;
            mctl.conj_a = 1'b1; op = pne_pkg::OP_T2_ADD;
          end
          STEPW'(6): begin
            wsel = pne_pkg::W_C; osel = pne_pkg::OFS_M; lpol = !pol_q; op = pne_pkg::OP_T0;
          end
          STEPW'(7): begin osel = pne_pkg::OFS_N; b_src = pne_pkg::BSRC_T0; op = pne_pkg::OP_T0; end
          STEPW'(8): begin
            osel = pne_pkg::OFS_MN; lpol = !pol_q; b_src = pne_pkg::BSRC_T0;
            mctl.conj_a = 1'b1; op = pne_pkg::OP_T2_ADD;
          end
          default: begin
            a_src = pne_pkg::ASRC_CXPM; b_src = pne_pkg::BSRC_T2; op = pne_pkg::OP_ACC_ADD;
          end
        endcase
        if (step_q == pne_pkg::XPM_LAST) begin
          step_d = '0;
          if (last_n && last_m) begin
            state_d = pne_pkg::ST_FIN;
          end else if (last_n) begin
            m_d = m_next;
            n_d = n_first;
          end else begin
            n_d = n_q + (OFW + 1)'(1);
          end
        end else begin
          step_d = step_q + STEPW'(1);
        end
      end
      pne_pkg::ST_FIN: begin
        // Subtract from the received sample, then scale by the reciprocal weight.
        a_src = pne_pkg::ASRC_WGT;
        unique case (step_q)
          STEPW'(0): op = pne_pkg::OP_Q;
          STEPW'(1): begin b_src = pne_pkg::BSRC_QH; op = pne_pkg::OP_ACC_SET; end
          STEPW'(2): begin b_src = pne_pkg::BSRC_QL; op = pne_pkg::OP_ACC_SHADD; end
          default: op = pne_pkg::OP_OUT;
        endcase
        if (step_q == pne_pkg::FIN_LAST) begin
          step_d = '0;
          if (!pol_q) begin
            state_d = pne_pkg::ST_SPM;
            pol_d = 1'b1;
            m_d = -cr_s;
            n_d = '0;
          end else begin
            state_d = pne_pkg::ST_DONE;
          end
        end else begin
          step_d = step_q + STEPW'(1);
        end
      end
      pne_pkg::ST_DONE: begin
        if (load_out) begin
          state_d = pne_pkg::ST_IDLE;
        end
      end
      default: state_d = pne_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pne_pkg::ST_CLEAR;
      step_q <= '0;
      pol_q <= 1'b0;
      m_q <= '0;
      n_q <= '0;
      clr_q <= '0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      pol_q <= pol_d;
      m_q <= m_d;
      n_q <= n_d;
      clr_q <= clr_d;
    end
  end

  // Operand A: one window entry, a coefficient or the weight.
  assign np = right_s ? -n_q : n_q;
  always_comb begin
    unique case (osel)
      pne_pkg::OFS_M: dsel = m_q;
      pne_pkg::OFS_N: dsel = np;
      default:        dsel = m_q + np;
    endcase
  end
  assign d_idx = dsel + MAX_S;
  assign smp_idx = d_idx[IDXW-1:0];

  always_comb begin
    unique case (wsel)
      pne_pkg::W_L: smp_word = lwin_q[smp_idx];
      pne_pkg::W_R: smp_word = rwin_q[smp_idx];
      default:      smp_word = cwin_q[smp_idx];
    endcase
  end

  always_comb begin
    unique case (a_src)
      pne_pkg::ASRC_SMP: begin
        a_op.re = OPW'(signed'(lpol ? smp_word[47:32] : smp_word[15:0]));
        a_op.im = OPW'(signed'(lpol ? smp_word[63:48] : smp_word[31:16]));
      end
      pne_pkg::ASRC_CSPM: begin
        a_op.re = OPW'(signed'(cs_q[2*LANEW-1:LANEW]));
        a_op.im = OPW'(signed'(cs_q[LANEW-1:0]));
      end
      pne_pkg::ASRC_CXPM: begin
        a_op.re = OPW'(signed'(cx_q[2*LANEW-1:LANEW]));
        a_op.im = OPW'(signed'(cx_q[LANEW-1:0]));
      end
      default: begin
        a_op.re = OPW'(inv_w_re_q);
        a_op.im = OPW'(inv_w_im_q);
      end
    endcase
  end

  // Operand B: a temporary, a part of the difference, or one at scale 2^14.
  always_comb begin
    unique case (b_src)
      pne_pkg::BSRC_T0: b_op = t0_q;
      pne_pkg::BSRC_T1: b_op = t1_q;
      pne_pkg::BSRC_T2: b_op = t2_q;
      pne_pkg::BSRC_QH: begin
        b_op.re = OPW'(q_re_q >>> QLOW);
        b_op.im = OPW'(q_im_q >>> QLOW);
      end
      pne_pkg::BSRC_QL: begin
        b_op.re = OPW'({1'b0, q_re_q[QLOW-1:0]});
        b_op.im = OPW'({1'b0, q_im_q[QLOW-1:0]});
      end
      default: begin
        b_op.re = OPW'(1 << FRAC);
        b_op.im = '0;
      end
    endcase
  end

  pne_cmul u_cmul (
    .a_i   (a_op),
    .b_i   (b_op),
    .ctrl_i(mctl),
    .p_o   (prod)
  );

  assign rp_re = pne_pkg::rnd_op(prod.re);
  assign rp_im = pne_pkg::rnd_op(prod.im);

  // Final arithmetic on the accumulator.
  assign rx_re = signed'(pol_q ? rxd_q[0][47:32] : rxd_q[0][15:0]);
  assign rx_im = signed'(pol_q ? rxd_q[0][63:48] : rxd_q[0][31:16]);
  assign qt_re = ((ACCW'(rx_re) <<< FRAC) - acc_re_q + Q_HALF) >>> FRAC;
  assign qt_im = ((ACCW'(rx_im) <<< FRAC) - acc_im_q + Q_HALF) >>> FRAC;
  assign ow_re = (acc_re_q + W_HALF) >>> WFRAC;
  assign ow_im = (acc_im_q + W_HALF) >>> WFRAC;

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_s) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end
    unique case (op)
      pne_pkg::OP_T0: begin
        t0_q.re <= rp_re;
        t0_q.im <= rp_im;
      end
      pne_pkg::OP_T1_SET: begin
        t1_q.re <= rp_re;
        t1_q.im <= rp_im;
      end
      pne_pkg::OP_T1_ADD: begin
        t1_q.re <= t1_q.re + rp_re;
        t1_q.im <= t1_q.im + rp_im;
      end
      pne_pkg::OP_T2_SET2: begin
        t2_q.re <= rp_re <<< 1;
        t2_q.im <= rp_im <<< 1;
      end
      pne_pkg::OP_T2_ADD2: begin
        t2_q.re <= t2_q.re + (rp_re <<< 1);
        t2_q.im <= t2_q.im + (rp_im <<< 1);
      end
      pne_pkg::OP_T2_ADD: begin
        t2_q.re <= t2_q.re + rp_re;
        t2_q.im <= t2_q.im + rp_im;
      end
      pne_pkg::OP_ACC_ADD: begin
        acc_re_q <= acc_re_q + ACCW'(prod.re);
        acc_im_q <= acc_im_q + ACCW'(prod.im);
      end
      pne_pkg::OP_ACC_SET: begin
        acc_re_q <= ACCW'(prod.re);
        acc_im_q <= ACCW'(prod.im);
      end
      pne_pkg::OP_ACC_SHADD: begin
        acc_re_q <= (acc_re_q <<< QLOW) + ACCW'(prod.re);
        acc_im_q <= (acc_im_q <<< QLOW) + ACCW'(prod.im);
      end
      pne_pkg::OP_Q: begin
        q_re_q <= QW'(qt_re);
        q_im_q <= QW'(qt_im);
      end
      pne_pkg::OP_OUT: begin
        if (pol_q) begin
          res_q[2] <= pne_pkg::sat16(ow_re);
          res_q[3] <= pne_pkg::sat16(ow_im);
        end else begin
          res_q[0] <= pne_pkg::sat16(ow_re);
          res_q[1] <= pne_pkg::sat16(ow_im);
        end
        acc_re_q <= '0;
        acc_im_q <= '0;
      end
      default: ;
    endcase
  end

  // Output register: holds a finished result until its transfer.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int i = 0; i < 4; i++) begin
        out_q[i] <= res_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign eq_x_re_o = out_q[0];
  assign eq_x_im_o = out_q[1];
  assign eq_y_re_o = out_q[2];
  assign eq_y_im_o = out_q[3];

`ifndef SYNTH
  // The walk never leaves the diamond of the active radius.
  a_in_diamond: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == pne_pkg::ST_SPM || state_q == pne_pkg::ST_XPM) |->
      (mabs + nabs <= rad_s))
    else $error("diamond walk left the active radius");

  // A sample that completes the window starts the sequencer and stalls the input.
  a_start_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
      start_s |=> (in_stall_o && state_q == pne_pkg::ST_SPM))
    else $error("sequencer did not start after a full window");

  // A new result appears only when a computation has just finished.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> $past(state_q == pne_pkg::ST_DONE))
    else $error("result shown without a finished computation");
`endif

endmodule

`default_nettype wire

### test/perturbation_nonlinear_equalizer_top_tb.sv
`default_nettype none

module perturbation_nonlinear_equalizer_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int LONG_HOLD = 3000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [1:0]  req;
    logic [8:0]  idx;
    logic [15:0] cre;
    logic [15:0] cim;
    logic [63:0] tl;
    logic [63:0] tc;
    logic [63:0] tr;
    logic [63:0] rx;
    bit          has_eq;
    logic [63:0] eq_word;
  } eq_req_t;

  typedef struct {
    longint re;
    longint im;
  } cplx_t;

  typedef struct {
    int spm_r;
    int xpm_r;
    int w_re;
    int w_im;
    int n_items;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = pne_pkg::CFG_SPM_RADIUS;
  logic [pne_pkg::CFGW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = pne_pkg::REQ_SAMPLE;
  logic [pne_pkg::ADRW-1:0] coef_index_i = '0;
  logic signed [pne_pkg::LANEW-1:0] coef_re_i = '0;
  logic signed [pne_pkg::LANEW-1:0] coef_im_i = '0;
  logic [pne_pkg::WORDW-1:0] tx_left_i = '0;
  logic [pne_pkg::WORDW-1:0] tx_center_i = '0;
  logic [pne_pkg::WORDW-1:0] tx_right_i = '0;
  logic [pne_pkg::WORDW-1:0] rx_center_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic signed [pne_pkg::LANEW-1:0] eq_x_re_o;
  logic signed [pne_pkg::LANEW-1:0] eq_x_im_o;
  logic signed [pne_pkg::LANEW-1:0] eq_y_re_o;
  logic signed [pne_pkg::LANEW-1:0] eq_y_im_o;

  perturbation_nonlinear_equalizer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .coef_index_i(coef_index_i),
    .coef_re_i   (coef_re_i),
    .coef_im_i   (coef_im_i),
    .tx_left_i   (tx_left_i),
    .tx_center_i (tx_center_i),
    .tx_right_i  (tx_right_i),
    .rx_center_i (rx_center_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .eq_x_re_o   (eq_x_re_o),
    .eq_x_im_o   (eq_x_im_o),
    .eq_y_re_o   (eq_y_re_o),
    .eq_y_im_o   (eq_y_im_o)
  );

  // Shadow state of the equalizer.
  logic [63:0] tx_hist [3][pne_pkg::WIN];
  logic [63:0] rx_hist [pne_pkg::MAX_RADIUS+1];
  logic [31:0] spm_lut [pne_pkg::NCOEF];
  logic [31:0] xpm_lut [pne_pkg::NCOEF];
  int fill_cnt;
  logic [3:0] spm_rad;
  logic [3:0] xpm_rad;
  logic [15:0] inv_w_re;
  logic [15:0] inv_w_im;

  eq_req_t send_q[$];
  logic [63:0] eq_fifo[$];
  int mismatches = 0;
  int n_results = 0;
  int cycles = 0;
  bit sender_idle = 1'b1;
  bit cur_has_eq = 1'b0;
  logic [63:0] cur_eq_word = '0;

  // Stimulus of the directed part: table writes at the edges of the index range,
  // an unused request and then enough samples to fill the windows. With the
  // center coefficient zero, unit weight gives the delayed received sample.
  eq_req_t dir_rows[24] = '{
    '{pne_pkg::REQ_SPM_COEF, 9'd0,   16'h7fff, 16'h8000, '0, '0, '0, '0, 0, '0},
    '{pne_pkg::REQ_SPM_COEF, 9'd288, 16'h8000, 16'h7fff, '0, '0, '0, '0, 0, '0},
    '{pne_pkg::REQ_XPM_COEF, 9'd0,   16'h8000, 16'h8000, '0, '0, '0, '0, 0, '0},
    '{pne_pkg::REQ_SPM_COEF, 9'd289, 16'h7fff, 16'h7fff, '0, '0, '0, '0, 0, '0},
    '{pne_pkg::REQ_XPM_COEF, 9'd511, 16'hffff, 16'hffff, '0, '0, '0, '0, 0, '0},
    '{REQ_UNUSED,   9'd144, 16'h1234, 16'h5678, '1, '1, '1, '1, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, 64'h8000_8000_8000_8000,
      64'h7fff_7fff_7fff_7fff, 64'hffff_ffff_ffff_ffff, 64'h0000_0000_0000_0000, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, 64'h7fff_7fff_7fff_7fff,
      64'h8000_8000_8000_8000, 64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, '0, '1, 64'h8000_7fff_8000_7fff,
      64'h1111_2222_3333_4444, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, '1, '0, 64'h7fff_8000_7fff_8000,
      64'h5555_6666_7777_8888, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, 64'h4000_c000_4000_c000,
      64'h2000_2000_e000_e000, 64'h0001_fffe_0002_fffd, 64'h9999_aaaa_bbbb_cccc, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, 64'h1234_5678_9abc_def0,
      64'h0fed_cba9_8765_4321, 64'h3c3c_c3c3_5a5a_a5a5, 64'hdddd_eeee_ffff_0000, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, 64'h8000_0000_7fff_0000,
      64'h0000_8000_0000_7fff, 64'h7fff_7fff_8000_8000, 64'h0f0f_f0f0_0f0f_f0f0, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, 64'h0001_0001_0001_0001,
      64'hfffe_fffe_fffe_fffe, 64'h4000_4000_4000_4000, 64'h1357_9bdf_2468_ace0, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, 64'h6000_a000_6000_a000,
      64'h7fff_8000_8000_7fff, 64'hc000_c000_c000_c000, 64'h7fff_8000_1234_abcd, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, 64'h5a5a_5a5a_5a5a_5a5a,
      64'ha5a5_a5a5_a5a5_a5a5, 64'h0000_ffff_0000_ffff, 64'h8000_7fff_ffff_0001, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, '1, '1, '1, 64'h0000_0000_0000_0001, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, '0, '0, '0, 64'h8000_8000_8000_8000, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, 64'h7fff_0000_8000_ffff,
      64'h2222_4444_6666_8888, 64'h1111_3333_5555_7777, 64'h7fff_7fff_7fff_7fff, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, 64'h0100_0200_0300_0400,
      64'h0500_0600_0700_0800, 64'h0900_0a00_0b00_0c00, 64'hffff_ffff_ffff_ffff, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, 64'hf000_e000_d000_c000,
      64'h8001_8002_7ffe_7ffd, 64'h0f00_0e00_0d00_0c00, 64'h4000_4000_4000_4000, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, 64'h3fff_c001_3fff_c001,
      64'h1000_f000_1000_f000, 64'h8000_8000_7fff_7fff, 64'hc000_c000_c000_c000, 0, '0},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, '1, '0, '1, 64'h0123_4567_89ab_cdef, 1,
      64'h7fff_8000_1234_abcd},
    '{pne_pkg::REQ_SAMPLE, 9'd0, 16'h0, 16'h0, '0, '1, '0, 64'hfedc_ba98_7654_3210, 1,
      64'h8000_7fff_ffff_0001}
  };

  // Settings walked by the random part; a weight of -1 in both fields means drawn.
  phase_t phases[10] = '{
    '{0, 0, 4096, 0, 120},
    '{1, 1, 3000, -2000, 150},
    '{2, 1, -1, -1, 150},
    '{1, 2, 1024, 4096, 150},
    '{0, 0, 32767, -32768, 100},
    '{2, 2, -32768, 32767, 100},
    '{15, 0, 4096, 0, 30},
    '{0, 15, -4096, 2048, 20},
    '{8, 8, 4096, 0, 12},
    '{3, 0, -1, -1, 100}
  };

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint rnd(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint lane_of(logic [63:0] w, int j);
    return longint'($signed(w[16*j +: 16]));
  endfunction

  function automatic cplx_t cmul(cplx_t a, cplx_t b);
    cplx_t r;
    r.re = a.re * b.re - a.im * b.im;
    r.im = a.re * b.im + a.im * b.re;
    return r;
  endfunction

  function automatic cplx_t cmul_rnd(cplx_t a, cplx_t b);
    cplx_t r;
    r = cmul(a, b);
    r.re = rnd(r.re, pne_pkg::FRAC);
    r.im = rnd(r.im, pne_pkg::FRAC);
    return r;
  endfunction

  function automatic cplx_t conj_of(cplx_t a);
    a.im = -a.im;
    return a;
  endfunction

  function automatic cplx_t cadd(cplx_t a, cplx_t b);
    a.re += b.re;
    a.im += b.im;
    return a;
  endfunction

  // Sample of channel ch (0 left, 1 center, 2 right) at offset d from the middle.
  function automatic cplx_t tap(int ch, int d, int pol);
    cplx_t r;
    int i;
    r = '{0, 0};
    i = pne_pkg::MAX_RADIUS + d;
    if (i >= 0 && i < pne_pkg::WIN) begin
      r.re = lane_of(tx_hist[ch][i], 2 * pol);
      r.im = lane_of(tx_hist[ch][i], 2 * pol + 1);
    end
    return r;
  endfunction

  function automatic cplx_t triple(cplx_t a, cplx_t b, cplx_t c);
    return cmul_rnd(cmul_rnd(a, b), conj_of(c));
  endfunction

  function automatic cplx_t spm_prod(int pol, int m, int n);
    cplx_t t;
    t = cadd(cmul_rnd(tap(1, n, 0), conj_of(tap(1, m + n, 0))),
             cmul_rnd(tap(1, n, 1), conj_of(tap(1, m + n, 1))));
    return cmul_rnd(tap(1, m, pol), t);
  endfunction

  function automatic cplx_t xpm_prod(int ch, int pol, int m, int n);
    cplx_t a, b, c;
    int q;
    q = 1 - pol;
    a = triple(tap(1, m, pol), tap(ch, n, pol), tap(ch, m + n, pol));
    b = triple(tap(1, m, pol), tap(ch, n, q), tap(ch, m + n, q));
    c = triple(tap(1, m, q), tap(ch, n, pol), tap(ch, m + n, q));
    a.re *= 2;
    a.im *= 2;
    return cadd(cadd(a, b), c);
  endfunction

  function automatic cplx_t coef_val(logic [31:0] w);
    cplx_t r;
    r.re = longint'($signed(w[31:16]));
    r.im = longint'($signed(w[15:0]));
    return r;
  endfunction

  function automatic longint sat_lane(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Advance the shadow state by one accepted transfer and form its result, if any.
  task automatic equalize(input eq_req_t it, output bit hit, output logic [63:0] res);
    int cr, dr, pol, m, n, b, ci;
    cplx_t acc, q, w, r;
    hit = 1'b0;
    res = '0;
    if (it.req == pne_pkg::REQ_SPM_COEF || it.req == pne_pkg::REQ_XPM_COEF) begin
      if (it.idx < pne_pkg::NCOEF) begin
        if (it.req == pne_pkg::REQ_SPM_COEF) spm_lut[it.idx] = {it.cre, it.cim};
        else xpm_lut[it.idx] = {it.cre, it.cim};
      end
      return;
    end
    if (it.req != pne_pkg::REQ_SAMPLE) return;
    for (int i = 0; i < pne_pkg::WIN - 1; i++) begin
      for (int c = 0; c < 3; c++) tx_hist[c][i] = tx_hist[c][i+1];
    end
    for (int i = 0; i < pne_pkg::MAX_RADIUS; i++) rx_hist[i] = rx_hist[i+1];
    tx_hist[0][pne_pkg::WIN-1] = it.tl;
    tx_hist[1][pne_pkg::WIN-1] = it.tc;
    tx_hist[2][pne_pkg::WIN-1] = it.tr;
    rx_hist[pne_pkg::MAX_RADIUS] = it.rx;
    if (fill_cnt < pne_pkg::WIN) fill_cnt++;
    if (fill_cnt < pne_pkg::WIN) return;
    cr = spm_rad > pne_pkg::MAX_RADIUS ? pne_pkg::MAX_RADIUS : int'(spm_rad);
    dr = xpm_rad > pne_pkg::MAX_RADIUS ? pne_pkg::MAX_RADIUS : int'(xpm_rad);
    for (pol = 0; pol < 2; pol++) begin
      acc = '{0, 0};
      for (m = -cr; m <= cr; m++) begin
        b = cr - (m < 0 ? -m : m);
        for (n = -b; n <= b; n++) begin
          ci = (m + pne_pkg::MAX_RADIUS) * pne_pkg::WIN + (n + pne_pkg::MAX_RADIUS);
          acc = cadd(acc, cmul(coef_val(spm_lut[ci]), spm_prod(pol, m, n)));
        end
      end
      for (m = -dr; m <= dr; m++) begin
        b = dr - (m < 0 ? -m : m);
        for (n = -b; n <= b; n++) begin
          ci = (m + pne_pkg::MAX_RADIUS) * pne_pkg::WIN + (n + pne_pkg::MAX_RADIUS);
          acc = cadd(acc, cmul(coef_val(xpm_lut[ci]),
                               cadd(xpm_prod(0, pol, m, n), xpm_prod(2, pol, m, -n))));
        end
      end
      q.re = rnd(lane_of(rx_hist[0], 2 * pol) * 16384 - acc.re, pne_pkg::FRAC);
      q.im = rnd(lane_of(rx_hist[0], 2 * pol + 1) * 16384 - acc.im, pne_pkg::FRAC);
      w.re = longint'($signed(inv_w_re));
      w.im = longint'($signed(inv_w_im));
      r = cmul(q, w);
      res[32*pol +: 16] = 16'(sat_lane(rnd(r.re, pne_pkg::WFRAC)));
      res[32*pol+16 +: 16] = 16'(sat_lane(rnd(r.im, pne_pkg::WFRAC)));
    end
    hit = 1'b1;
  endtask

  // Predict on every accepted input transfer.
  always @(posedge clk_i) begin
    bit hit;
    logic [63:0] res;
    eq_req_t it;
    if (in_valid_i && !in_stall_o) begin
      it = '{req_type_i, coef_index_i, coef_re_i, coef_im_i, tx_left_i, tx_center_i,
             tx_right_i, rx_center_i, 0, '0};
      it.has_eq = cur_has_eq;
      it.eq_word = cur_eq_word;
      equalize(it, hit, res);
      if (hit) eq_fifo.push_back(it.has_eq ? it.eq_word : res);
    end
  end

  // Check every accepted output transfer against the oldest expectation.
  always @(posedge clk_i) begin
    logic [63:0] want;
    logic [63:0] got;
    if (out_valid_o && !out_stall_i) begin
      n_results <= n_results + 1;
      got = {eq_y_im_o, eq_y_re_o, eq_x_im_o, eq_x_re_o};
      if (eq_fifo.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected result %h", got);
      end else begin
        want = eq_fifo.pop_front();
        if (got[15:0] !== want[15:0] || got[31:16] !== want[31:16] ||
            got[47:32] !== want[47:32] || got[63:48] !== want[63:48]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("Mismatch x_re %h/%h x_im %h/%h y_re %h/%h y_im %h/%h (exp/got)",
                     want[15:0], got[15:0], want[31:16], got[31:16],
                     want[47:32], got[47:32], want[63:48], got[63:48]);
          end
        end
      end
    end
  end

  // Sender: random gaps before each transfer, payload held while stalled.
  // Without a gap, the next item goes out at the very edge that took the previous one.
  initial begin
    eq_req_t it;
    int gap;
    @(posedge rst_ni);
    forever begin
      if (send_q.size() == 0) begin
        @(posedge clk_i);
      end else begin
        sender_idle = 1'b0;
        it = send_q.pop_front();
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        in_valid_i <= 1'b1;
        req_type_i <= it.req;
        coef_index_i <= it.idx;
        coef_re_i <= it.cre;
        coef_im_i <= it.cim;
        tx_left_i <= it.tl;
        tx_center_i <= it.tc;
        tx_right_i <= it.tr;
        rx_center_i <= it.rx;
        cur_has_eq <= it.has_eq;
        cur_eq_word <= it.eq_word;
        do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
        if (send_q.size() == 0) begin
          in_valid_i <= 1'b0;
          sender_idle = 1'b1;
        end
      end
    end
  end

  // Receiver: random stall per result, one long hold-off to back the block up.
  initial begin
    int hold;
    bit held = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) hold = 0;
      if (!held && n_results >= 40) begin
        hold = LONG_HOLD;
        held = 1'b1;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic write_cfg(input int sr, input int xr, input int wr, input int wi);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= pne_pkg::CFG_SPM_RADIUS;
    cfg_data_i <= pne_pkg::CFGW'(sr);
    spm_rad = 4'(sr);
    @(posedge clk_i);
    cfg_idx_i <= pne_pkg::CFG_XPM_RADIUS;
    cfg_data_i <= pne_pkg::CFGW'(xr);
    xpm_rad = 4'(xr);
    @(posedge clk_i);
    cfg_idx_i <= pne_pkg::CFG_INV_W_RE;
    cfg_data_i <= pne_pkg::CFGW'(wr);
    inv_w_re = 16'(wr);
    @(posedge clk_i);
    cfg_idx_i <= pne_pkg::CFG_INV_W_IM;
    cfg_data_i <= pne_pkg::CFGW'(wi);
    inv_w_im = 16'(wi);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Checked on the falling edge, once every process of the rising edge has run.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (send_q.size() > 0 || !sender_idle || eq_fifo.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_lane();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_word();
    return {pick_lane(), pick_lane(), pick_lane(), pick_lane()};
  endfunction

  function automatic logic [15:0] pick_coef();
    if ($urandom_range(0, 3) == 0) return pick_lane();
    return 16'($signed(11'($urandom)));
  endfunction

  // Random transfer; coefficient writes mostly land inside the active diamond.
  function automatic eq_req_t pick_req(int rad);
    eq_req_t it;
    int sel, m, n;
    it = '{pne_pkg::REQ_SAMPLE, '0, '0, '0, pick_word(), pick_word(), pick_word(),
           pick_word(), 0, '0};
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      it.req = ($urandom_range(0, 1) == 0) ? pne_pkg::REQ_SPM_COEF : pne_pkg::REQ_XPM_COEF;
      it.cre = pick_coef();
      it.cim = pick_coef();
      if (rad > pne_pkg::MAX_RADIUS) rad = pne_pkg::MAX_RADIUS;
      if ($urandom_range(0, 7) == 0) begin
        it.idx = 9'($urandom);
      end else begin
        m = $urandom_range(0, 2 * rad) - rad;
        n = $urandom_range(0, 2 * (rad - (m < 0 ? -m : m))) - (rad - (m < 0 ? -m : m));
        it.idx = 9'((m + pne_pkg::MAX_RADIUS) * pne_pkg::WIN + n + pne_pkg::MAX_RADIUS);
      end
    end else if (sel < 23) begin
      it.req = REQ_UNUSED;
    end
    return it;
  endfunction

  initial begin
    int rad, wr, wi;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < pne_pkg::WIN; i++) tx_hist[c][i] = '0;
    end
    for (int i = 0; i <= pne_pkg::MAX_RADIUS; i++) rx_hist[i] = '0;
    for (int i = 0; i < pne_pkg::NCOEF; i++) begin
      spm_lut[i] = '0;
      xpm_lut[i] = '0;
    end
    fill_cnt = 0;
    spm_rad = '0;
    xpm_rad = '0;
    inv_w_re = 16'd4096;
    inv_w_im = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset settings.
    foreach (dir_rows[i]) send_q.push_back(dir_rows[i]);
    wait_drained();

    // Random part, one configuration per phase.
    foreach (phases[p]) begin
      wr = phases[p].w_re;
      wi = phases[p].w_im;
      if (wr == -1 && wi == -1) begin
        wr = $urandom_range(0, 65535);
        wi = $urandom_range(0, 65535);
      end
      write_cfg(phases[p].spm_r, phases[p].xpm_r, wr, wi);
      rad = phases[p].spm_r > phases[p].xpm_r ? phases[p].spm_r : phases[p].xpm_r;
      for (int k = 0; k < phases[p].n_items; k++) send_q.push_back(pick_req(rad));
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
sv/pne_pkg.sv
sv/pne_cmul.sv
sv/perturbation_nonlinear_equalizer_top.sv
test/perturbation_nonlinear_equalizer_top_tb.sv
